@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define VSA_ASSERT_IMPLY(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

// condition that must never be seen outside reset
`define VSA_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("assertion failed");

`endif

@@ sv/vsa_pkg.sv @@
`timescale 1ns / 1ps
package vsa_pkg;

  localparam int OUT_BITS = 48;
  localparam int FIELD_BITS = 16;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 2;
  localparam int QDEPTH = 2;

  localparam logic [CFG_ADDR_BITS-1:0] ADDR_METRIC_SELECT = '0;

  typedef enum logic [1:0] {
    MET_DOT = 2'd0,
    MET_L2  = 2'd1,
    MET_COS = 2'd2
  } metric_t;

  typedef struct packed {
    logic    sat;
    metric_t metric;
  } vsa_tag_t;

endpackage

@@ sv/vsa_if.sv @@
`timescale 1ns / 1ps
interface vsa_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vsa_pkg::FIELD_BITS-1:0] elem_a;
  logic signed [vsa_pkg::FIELD_BITS-1:0] elem_b;
  logic                                last;

  modport source(output valid, elem_a, elem_b, last, input ready);
  modport sink(input valid, elem_a, elem_b, last, output ready);
endinterface

interface vsa_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vsa_pkg::OUT_BITS-1:0] metric_value;
  logic                                zero_norm;
  logic                                saturated;

  modport source(output valid, metric_value, zero_norm, saturated, input ready);
  modport sink(input valid, metric_value, zero_norm, saturated, output ready);
endinterface

@@ sv/vsa_front.sv @@
`timescale 1ns / 1ps
module vsa_front #(
  parameter int ELEM_BITS = 16,
  parameter int ACC_BITS = 48
) (
  input  logic                       clk,
  input  logic                       rst,
  vsa_in_if.sink                     items,
  input  vsa_pkg::metric_t           metric,
  input  logic                       q_full,
  output logic                       push,
  output logic signed [ACC_BITS-1:0] push_dot,
  output logic signed [ACC_BITS-1:0] push_dsq,
  output logic signed [ACC_BITS-1:0] push_na,
  output logic signed [ACC_BITS-1:0] push_nb,
  output vsa_pkg::vsa_tag_t          push_tag
);
  import vsa_pkg::*;

  localparam int XB = (ELEM_BITS > FIELD_BITS) ? ELEM_BITS : FIELD_BITS;
  localparam int PW = 2 * ELEM_BITS + 2;
  localparam int SW = ((ACC_BITS > PW) ? ACC_BITS : PW) + 2;
  localparam logic signed [SW-1:0] ACC_MAX = (SW'(1) <<< (ACC_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] ACC_MIN = -ACC_MAX - SW'(1);

  function automatic logic [ACC_BITS:0] sat_add(input logic signed [ACC_BITS-1:0] acc,
                                                input logic signed [PW-1:0] t);
    logic signed [SW-1:0] s;
    s = SW'(acc) + SW'(t);
    if (s > ACC_MAX) begin
      sat_add = {1'b1, ACC_MAX[ACC_BITS-1:0]};
    end else if (s < ACC_MIN) begin
      sat_add = {1'b1, ACC_MIN[ACC_BITS-1:0]};
    end else begin
      sat_add = {1'b0, s[ACC_BITS-1:0]};
    end
  endfunction

  logic [XB-1:0]               wa, wb;
  logic signed [ELEM_BITS-1:0] ea, eb;
  logic signed [ELEM_BITS:0]   df;
  logic signed [2*ELEM_BITS-1:0] m_ab, m_aa, m_bb;
  logic signed [2*ELEM_BITS+1:0] m_dd;

  logic                 p1_valid, p1_last;
  logic signed [PW-1:0] p1_ab, p1_dd, p1_aa, p1_bb;
  logic                 advance;

  logic signed [ACC_BITS-1:0] dot, dsq, na, nb;
  logic                       sat;
  logic [ACC_BITS:0]          s_dot, s_dsq, s_na, s_nb;
  logic                       sat_next;

  // elements are the low ELEM_BITS bits of the fields, sign taken from the top one
  assign wa = XB'($unsigned(items.elem_a));
  assign wb = XB'($unsigned(items.elem_b));
  assign ea = $signed(wa[ELEM_BITS-1:0]);
  assign eb = $signed(wb[ELEM_BITS-1:0]);
  assign df = (ELEM_BITS + 1)'(ea) - (ELEM_BITS + 1)'(eb);
  assign m_ab = ea * eb;
  assign m_aa = ea * ea;
  assign m_bb = eb * eb;
  assign m_dd = df * df;

  // the accumulate stage only waits when it holds a last word and the queue is full
  assign advance = !(p1_valid && p1_last && q_full);
  assign items.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (advance) begin
      p1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_last <= items.last;
      p1_ab <= PW'(m_ab);
      p1_aa <= PW'(m_aa);
      p1_bb <= PW'(m_bb);
      p1_dd <= PW'(m_dd);
    end
  end

  assign s_dot = sat_add(dot, p1_ab);
  assign s_dsq = sat_add(dsq, p1_dd);
  assign s_na = sat_add(na, p1_aa);
  assign s_nb = sat_add(nb, p1_bb);
  assign sat_next = sat | s_dot[ACC_BITS] | s_dsq[ACC_BITS] | s_na[ACC_BITS] | s_nb[ACC_BITS];

  assign push = p1_valid && p1_last && advance;
  assign push_dot = s_dot[ACC_BITS-1:0];
  assign push_dsq = s_dsq[ACC_BITS-1:0];
  assign push_na = s_na[ACC_BITS-1:0];
  assign push_nb = s_nb[ACC_BITS-1:0];
  assign push_tag = '{sat: sat_next, metric: metric};

  always_ff @(posedge clk) begin
    if (rst) begin
      dot <= '0;
      dsq <= '0;
      na <= '0;
      nb <= '0;
      sat <= 1'b0;
    end else if (p1_valid && advance) begin
      if (p1_last) begin
        dot <= '0;
        dsq <= '0;
        na <= '0;
        nb <= '0;
        sat <= 1'b0;
      end else begin
        dot <= s_dot[ACC_BITS-1:0];
        dsq <= s_dsq[ACC_BITS-1:0];
        na <= s_na[ACC_BITS-1:0];
        nb <= s_nb[ACC_BITS-1:0];
        sat <= sat_next;
      end
    end
  end

endmodule

@@ sv/vsa_fifo.sv @@
`timescale 1ns / 1ps
module vsa_fifo #(
  parameter int WIDTH = 194
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  import vsa_pkg::*;

  localparam int PTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_BITS = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0]    mem [QDEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full = (count == CNT_BITS'(QDEPTH));
  assign empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/vsa_back.sv @@
`timescale 1ns / 1ps
module vsa_back #(
  parameter int ACC_BITS = 48,
  parameter int COS_FRAC_BITS = 30
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  logic signed [ACC_BITS-1:0] q_dot,
  input  logic signed [ACC_BITS-1:0] q_dsq,
  input  logic signed [ACC_BITS-1:0] q_na,
  input  logic signed [ACC_BITS-1:0] q_nb,
  input  vsa_pkg::vsa_tag_t          q_tag,
  output logic                       pop,
  output logic                       idle,
  vsa_out_if.source                  results
);
  import vsa_pkg::*;

  localparam int PW = 2 * ACC_BITS;
  localparam int QB = 2 * COS_FRAC_BITS + 4;
  localparam int RB = QB / 2;
  localparam int SRW = RB + 2;
  localparam int CB = (QB > ACC_BITS) ? $clog2(QB) : $clog2(ACC_BITS);
  localparam int VW = COS_FRAC_BITS + 2;
  localparam int XW = (ACC_BITS > OUT_BITS) ? ACC_BITS : OUT_BITS;
  localparam logic [VW-1:0] ONE = VW'(1) << COS_FRAC_BITS;
  localparam logic signed [XW-1:0] OMAX = (XW'(1) <<< (OUT_BITS - 1)) - XW'(1);
  localparam logic signed [XW-1:0] OMIN = -OMAX - XW'(1);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MULA  = 8'b0000_0010,
    ST_MULB  = 8'b0000_0100,
    ST_CHECK = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_SQRT  = 8'b0010_0000,
    ST_ROUND = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [ACC_BITS-1:0] mag;
  logic                neg;
  logic [PW-1:0]       mc, prod, prod_next, msq, pr;
  logic [ACC_BITS-1:0] mp, nb_hold;
  logic [CB-1:0]       cnt;
  logic [PW-1:0]       rem;
  logic [PW:0]         rem_t;
  logic [QB-1:0]       dlow, quo;
  logic [QB-1:0]       sd;
  logic [RB-1:0]       root;
  logic [SRW-1:0]      srem;
  logic [SRW+1:0]      srem_t, trial;
  logic [RB:0]         qv;
  logic [VW-1:0]       qc;
  logic                rem_ge, root_ge;

  logic signed [XW-1:0] sel_wide;
  logic signed [OUT_BITS-1:0] clamp_val;
  logic                 clamp_sat;

  logic signed [OUT_BITS-1:0] res_value;
  logic                       res_zn, res_sat;

  assign idle = (state == ST_IDLE);
  assign pop = idle && !q_empty;
  assign results.valid = (state == ST_DONE);
  assign results.metric_value = res_value;
  assign results.zero_norm = res_zn;
  assign results.saturated = res_sat;

  assign mag = q_dot[ACC_BITS-1] ? (~q_dot + 1'b1) : q_dot;
  assign prod_next = prod + (mp[0] ? mc : '0);

  // one quotient bit of the scaled square over the norm product per cycle
  assign rem_t = {rem, dlow[QB-1]};
  assign rem_ge = (rem_t >= {1'b0, pr});

  // one root bit per cycle, two dividend bits in
  assign srem_t = {srem, sd[QB-1:QB-2]};
  assign trial = {root, 2'b01};
  assign root_ge = (srem_t >= trial);

  assign qv = ({1'b0, root} + 1'b1) >> 1;
  assign qc = ((RB + 1 > VW) ? (qv > (RB + 1)'(ONE)) : 1'b0) ? ONE : VW'(qv);

  always_comb begin
    case (q_tag.metric)
      MET_L2:  sel_wide = XW'(q_dsq);
      default: sel_wide = XW'(q_dot);
    endcase
    clamp_sat = 1'b0;
    if (sel_wide > OMAX) begin
      clamp_val = OMAX[OUT_BITS-1:0];
      clamp_sat = 1'b1;
    end else if (sel_wide < OMIN) begin
      clamp_val = OMIN[OUT_BITS-1:0];
      clamp_sat = 1'b1;
    end else begin
      clamp_val = sel_wide[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_tag.metric == MET_COS && q_na != '0 && q_nb != '0) begin
              state <= ST_MULA;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_MULA: begin
          if (cnt == CB'(ACC_BITS - 1)) state <= ST_MULB;
        end
        ST_MULB: begin
          if (cnt == CB'(ACC_BITS - 1)) state <= ST_CHECK;
        end
        ST_CHECK: begin
          if ({2'b00, msq} >= {pr, 2'b00}) state <= ST_DONE;
          else state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == CB'(QB - 1)) state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (cnt == CB'(RB - 1)) state <= ST_ROUND;
        end
        ST_ROUND: state <= ST_DONE;
        ST_DONE: begin
          if (results.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        neg <= q_dot[ACC_BITS-1];
        res_sat <= q_tag.sat;
        res_zn <= 1'b0;
        mc <= PW'(mag);
        mp <= mag;
        nb_hold <= q_nb;
        prod <= '0;
        cnt <= '0;
        // second multiply takes the norm of the first vector from here
        msq <= PW'(q_na);
        if (q_tag.metric == MET_COS) begin
          if (q_na == '0 || q_nb == '0) begin
            res_value <= '0;
            res_zn <= 1'b1;
          end
        end else begin
          res_value <= clamp_val;
          res_sat <= q_tag.sat | clamp_sat;
        end
      end
      ST_MULA: begin
        mc <= mc << 1;
        mp <= mp >> 1;
        prod <= prod_next;
        cnt <= cnt + 1'b1;
        if (cnt == CB'(ACC_BITS - 1)) begin
          mc <= msq;
          mp <= nb_hold;
          msq <= prod_next;
          prod <= '0;
          cnt <= '0;
        end
      end
      ST_MULB: begin
        mc <= mc << 1;
        mp <= mp >> 1;
        prod <= prod_next;
        cnt <= cnt + 1'b1;
        if (cnt == CB'(ACC_BITS - 1)) begin
          pr <= prod_next;
          cnt <= '0;
        end
      end
      ST_CHECK: begin
        rem <= msq >> 2;
        dlow <= {msq[1:0], {(QB - 2){1'b0}}};
        quo <= '0;
        cnt <= '0;
        // ratio at or beyond four means the rounded magnitude is capped at one
        res_value <= neg ? OUT_BITS'(ONE << 1) : '0;
      end
      ST_DIV: begin
        rem <= rem_ge ? PW'(rem_t - {1'b0, pr}) : PW'(rem_t);
        quo <= {quo[QB-2:0], rem_ge};
        dlow <= dlow << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CB'(QB - 1)) begin
          sd <= {quo[QB-2:0], rem_ge};
          root <= '0;
          srem <= '0;
          cnt <= '0;
        end
      end
      ST_SQRT: begin
        srem <= root_ge ? SRW'(srem_t - trial) : SRW'(srem_t);
        root <= {root[RB-2:0], root_ge};
        sd <= sd << 2;
        cnt <= cnt + 1'b1;
      end
      ST_ROUND: begin
        res_value <= neg ? OUT_BITS'(ONE + qc) : OUT_BITS'(ONE - qc);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/vector_similarity_accumulator.sv @@
`timescale 1ns / 1ps
// Vector similarity accumulator: takes one element pair of two vectors per clock and keeps
// saturating sums of a*b, (a-b)^2, a^2 and b^2; on the word marked last it returns one
// result for the metric held in metric_select (dot product, squared L2 distance or cosine
// distance with COS_FRAC_BITS fraction bits). Element pairs stream in at one per cycle; each
// finished vector pair goes to a two-entry queue, and the input only stalls while a last
// word waits behind a full queue. A dot or L2 result passes the accumulate stage register and
// the queue before the metric unit offers it, and that unit works on one vector pair at a
// time. For a cosine result a bit-serial multiplier forms |dot|^2 and the norm product, a
// restoring divider yields one quotient bit per cycle and a digit-by-digit square root one
// root bit per cycle. A zero norm gives a cosine result of 0 with zero_norm set.
module vector_similarity_accumulator #(
  parameter int ELEM_BITS = 16,
  parameter int ACC_BITS = 48,
  parameter int COS_FRAC_BITS = 30
) (
  input  logic                                clk,
  input  logic                                rst,
  vsa_in_if.sink                              items,
  vsa_out_if.source                           results,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vsa_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [vsa_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [vsa_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import vsa_pkg::*;
  `include "assert_macros.svh"

  localparam int TW = $bits(vsa_tag_t);
  localparam int QW = 4 * ACC_BITS + TW;

  metric_t metric_select;

  logic                       q_push, q_pop, q_full, q_empty, back_idle;
  logic signed [ACC_BITS-1:0] f_dot, f_dsq, f_na, f_nb;
  vsa_tag_t                   f_tag;
  logic [QW-1:0]              q_wr, q_rd;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_METRIC_SELECT) ? CFG_DATA_BITS'(metric_select) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_select <= MET_DOT;
    end else if (psel && penable && pwrite && paddr == ADDR_METRIC_SELECT) begin
      metric_select <= metric_t'(pwdata[1:0]);
    end
  end

  vsa_front #(
    .ELEM_BITS(ELEM_BITS),
    .ACC_BITS(ACC_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .items(items),
    .metric(metric_select),
    .q_full(q_full),
    .push(q_push),
    .push_dot(f_dot),
    .push_dsq(f_dsq),
    .push_na(f_na),
    .push_nb(f_nb),
    .push_tag(f_tag)
  );

  assign q_wr = {f_dot, f_dsq, f_na, f_nb, f_tag};

  vsa_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .wr_data(q_wr),
    .pop(q_pop),
    .rd_data(q_rd),
    .full(q_full),
    .empty(q_empty)
  );

  vsa_back #(
    .ACC_BITS(ACC_BITS),
    .COS_FRAC_BITS(COS_FRAC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_dot(q_rd[QW-1 -: ACC_BITS]),
    .q_dsq(q_rd[QW-1-ACC_BITS -: ACC_BITS]),
    .q_na(q_rd[QW-1-2*ACC_BITS -: ACC_BITS]),
    .q_nb(q_rd[QW-1-3*ACC_BITS -: ACC_BITS]),
    .q_tag(vsa_tag_t'(q_rd[TW-1:0])),
    .pop(q_pop),
    .idle(back_idle),
    .results(results)
  );

  `VSA_ASSERT_IMPLY(a_zero_norm_value, clk, rst, results.valid && results.zero_norm |-> results.metric_value == '0)
  `VSA_ASSERT_NEVER(a_push_when_full, clk, rst, q_push && q_full)
  `VSA_ASSERT_NEVER(a_pop_when_busy, clk, rst, q_pop && (q_empty || !back_idle))

endmodule
